// ===== sv/dti_pkg.sv =====
package dti_pkg;

    localparam int CODE_BITS = 12;
    localparam int LEVEL_BITS = 8;
    localparam int NTRIMS = 5;
    localparam int TRIM_IDX_BITS = $clog2(NTRIMS);
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISPLAY_PEAK = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASTER_PEAK  = 2'd1;

    localparam logic [LEVEL_BITS-1:0] TRIM_LEVEL = 8'd2;

    localparam logic [CODE_BITS-1:0] CODE_MAX = '1;
    localparam logic [CODE_BITS-1:0] NEUTRAL = {1'b1, {(CODE_BITS-1){1'b0}}};
    localparam logic [CODE_BITS-1:0] DISPLAY_PEAK_RST = 12'd2081;
    localparam logic [CODE_BITS-1:0] MASTER_PEAK_RST  = 12'd3079;

    typedef logic [NTRIMS-1:0][CODE_BITS-1:0] trims_t;

    // slope 1, offset 0, power 1, chroma 0, saturation 0
    localparam trims_t DEFAULT_TRIMS = {12'd0, 12'd0, 12'd1, 12'd0, 12'd1};
    localparam trims_t NEUTRAL_TRIMS = {NTRIMS{NEUTRAL}};

    typedef enum logic [1:0] {
        CASE_NONE      = 2'd0,
        CASE_BETWEEN   = 2'd1,
        CASE_ABOVE_ALL = 2'd2,
        CASE_BELOW_ALL = 2'd3
    } case_t;

    // one finished frame: blend base toward goal by num / den (den 0 -> hold base)
    typedef struct packed {
        logic                 trims_valid;
        case_t                kase;
        logic [CODE_BITS-1:0] num;
        logic [CODE_BITS-1:0] den;
        trims_t               base;
        trims_t               goal;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_MULT,
        BK_ACCUM,
        BK_DONE
    } back_state_t;

endpackage

// ===== sv/display_trim_interpolator_unit.sv =====
// Display trim interpolator.
// Input channel (in_valid / in_stall): one metadata entry per beat. Entries
// that are not level 2 only mark the frame end when final_entry is set.
// Entries are taken one per cycle unless stalled; the final entry hands the
// classified frame to a two-deep job queue and clears the selection state.
// Output channel (out_valid / out_stall): one result beat per frame.
// From the final entry's beat, the frame passes through the job queue to the
//   back end, which divides num by den unless den is 0 or num >= den, then
//   blends the trims and loads the result register.
// The divide is a restoring divider at one quotient bit per cycle; the five
// blends share one multiplier: a multiply and an accumulate state each.
// in_stall rises while the job queue is full, i.e. when two frames wait
// behind the back end; a stalled output holds its beat and the back end
// may finish one more frame into its done state meanwhile.
// Config (cfg_valid / cfg_ready, always ready): index 0 display peak,
// index 1 master peak, as 12-bit PQ codes. Reset: peaks to 2081 / 3079,
// selection state cleared, queue and output empty.
module display_trim_interpolator_unit #(
    parameter int WEIGHT_FRAC_BITS = dti_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dti_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dti_pkg::CODE_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dti_pkg::LEVEL_BITS-1:0]       entry_level,
    input  logic [dti_pkg::CODE_BITS-1:0]        target_code,
    input  logic [dti_pkg::CODE_BITS-1:0]        slope_trim,
    input  logic [dti_pkg::CODE_BITS-1:0]        offset_trim,
    input  logic [dti_pkg::CODE_BITS-1:0]        power_trim,
    input  logic [dti_pkg::CODE_BITS-1:0]        chroma_trim,
    input  logic [dti_pkg::CODE_BITS-1:0]        saturation_trim,
    input  logic                                 final_entry,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 trims_valid,
    output logic [1:0]                           case_taken,
    output logic [dti_pkg::CODE_BITS:0]          slope_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] offset_coef,
    output logic [dti_pkg::CODE_BITS:0]          power_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] chroma_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] saturation_coef
);
    import dti_pkg::*;

    logic   in_accept, q_push, q_full, q_pop, q_empty;
    job_t   q_in, q_head;
    trims_t in_trims;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;
    assign in_trims  = {saturation_trim, chroma_trim, power_trim, offset_trim, slope_trim};

    dti_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_accept   (in_accept),
        .entry_level (entry_level),
        .target_code (target_code),
        .trims       (in_trims),
        .final_entry (final_entry),
        .push        (q_push),
        .push_data   (q_in)
    );

    dti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    dti_back #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .trims_valid     (trims_valid),
        .case_taken      (case_taken),
        .slope_coef      (slope_coef),
        .offset_coef     (offset_coef),
        .power_coef      (power_coef),
        .chroma_coef     (chroma_coef),
        .saturation_coef (saturation_coef)
    );

endmodule

// ===== sv/dti_queue.sv =====
module dti_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dti_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output dti_pkg::job_t head,
    output logic          empty
);
    import dti_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
`endif

endmodule

// ===== sv/dti_front.sv =====
module dti_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dti_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dti_pkg::CODE_BITS-1:0]       cfg_data,
    input  logic                                in_accept,
    input  logic [dti_pkg::LEVEL_BITS-1:0]      entry_level,
    input  logic [dti_pkg::CODE_BITS-1:0]       target_code,
    input  dti_pkg::trims_t                     trims,
    input  logic                                final_entry,
    output logic                                push,
    output dti_pkg::job_t                       push_data
);
    import dti_pkg::*;

    logic [CODE_BITS-1:0] disp_reg, master_reg;
    logic                 any_reg, any_next;
    logic                 bf_reg, bf_next;
    logic [CODE_BITS-1:0] bd_reg, bd_next;
    logic [CODE_BITS-1:0] bt_reg, bt_next;
    trims_t               btr_reg, btr_next;
    logic                 af_reg, af_next;
    logic [CODE_BITS-1:0] ad_reg, ad_next;
    logic [CODE_BITS-1:0] at_reg, at_next;
    trims_t               atr_reg, atr_next;

    logic                 is_l2, at_or_below, take_below, take_above;
    logic [CODE_BITS-1:0] dist_below, dist_above;

    assign is_l2       = entry_level == TRIM_LEVEL;
    assign at_or_below = target_code <= disp_reg;
    assign dist_below  = disp_reg - target_code;
    assign dist_above  = target_code - disp_reg;
    assign take_below  = is_l2 && at_or_below && (dist_below < bd_reg);
    assign take_above  = is_l2 && !at_or_below && (dist_above < ad_reg);

    assign any_next = any_reg | is_l2;
    assign bf_next  = bf_reg | take_below;
    assign bd_next  = take_below ? dist_below : bd_reg;
    assign bt_next  = take_below ? target_code : bt_reg;
    assign btr_next = take_below ? trims : btr_reg;
    assign af_next  = af_reg | take_above;
    assign ad_next  = take_above ? dist_above : ad_reg;
    assign at_next  = take_above ? target_code : at_reg;
    assign atr_next = take_above ? trims : atr_reg;

    assign push = in_accept && final_entry;

    // classify the frame as it stands after this beat
    always_comb
    begin
        push_data             = '0;
        push_data.trims_valid = any_next;
        push_data.kase        = CASE_NONE;
        push_data.base        = DEFAULT_TRIMS;
        push_data.goal        = DEFAULT_TRIMS;
        priority if (!any_next)
        begin
            push_data.base = '0;
            push_data.goal = '0;
        end
        else if (bf_next && af_next)
        begin
            push_data.kase = CASE_BETWEEN;
            push_data.num  = disp_reg - bt_next;
            push_data.den  = at_next - bt_next;
            push_data.base = btr_next;
            push_data.goal = atr_next;
        end
        else if (bf_next)
        begin
            push_data.kase = CASE_ABOVE_ALL;
            push_data.num  = disp_reg - bt_next;
            push_data.den  = (master_reg > bt_next) ? master_reg - bt_next : '0;
            push_data.base = btr_next;
            push_data.goal = NEUTRAL_TRIMS;
        end
        else if (af_next)
        begin
            push_data.kase = CASE_BELOW_ALL;
            push_data.base = atr_next;
            push_data.goal = atr_next;
        end
        else
        begin
            push_data.kase = CASE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg   <= DISPLAY_PEAK_RST;
            master_reg <= MASTER_PEAK_RST;
            any_reg    <= 1'b0;
            bf_reg     <= 1'b0;
            bd_reg     <= CODE_MAX;
            af_reg     <= 1'b0;
            ad_reg     <= CODE_MAX;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_DISPLAY_PEAK))
            begin
                disp_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_MASTER_PEAK))
            begin
                master_reg <= cfg_data;
            end
            if (in_accept)
            begin
                if (final_entry)
                begin
                    any_reg <= 1'b0;
                    bf_reg  <= 1'b0;
                    bd_reg  <= CODE_MAX;
                    af_reg  <= 1'b0;
                    ad_reg  <= CODE_MAX;
                end
                else
                begin
                    any_reg <= any_next;
                    bf_reg  <= bf_next;
                    bd_reg  <= bd_next;
                    af_reg  <= af_next;
                    ad_reg  <= ad_next;
                end
            end
        end
    end

    // targets and trims are read only while their found flag is set
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bt_reg  <= bt_next;
            btr_reg <= btr_next;
            at_reg  <= at_next;
            atr_reg <= atr_next;
        end
    end

endmodule

// ===== sv/dti_back.sv =====
module dti_back #(
    parameter int WEIGHT_FRAC_BITS = dti_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dti_pkg::job_t                  head,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           trims_valid,
    output logic [1:0]                     case_taken,
    output logic [dti_pkg::CODE_BITS:0]    slope_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] offset_coef,
    output logic [dti_pkg::CODE_BITS:0]    power_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] chroma_coef,
    output logic signed [dti_pkg::CODE_BITS-1:0] saturation_coef
);
    import dti_pkg::*;

    localparam int DW = CODE_BITS + WEIGHT_FRAC_BITS + 1;
    localparam int CNT_BITS = $clog2(DW + 1);
    localparam int WW = WEIGHT_FRAC_BITS + 1;
    localparam int PW = CODE_BITS + WEIGHT_FRAC_BITS + 3;
    localparam logic [WW-1:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (WEIGHT_FRAC_BITS - 1);

    back_state_t state_reg, state_next;
    job_t                    job_reg;
    logic [DW-1:0]           dvd_reg, quo_reg, quo_next;
    logic [CODE_BITS-1:0]    rem_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [WW-1:0]           w_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [TRIM_IDX_BITS-1:0] idx_reg;
    trims_t                  res_reg;
    logic                    out_valid_reg;
    logic                    trims_valid_reg;
    logic [1:0]              case_reg;
    logic [CODE_BITS:0]      slope_reg, power_reg;
    logic [CODE_BITS-1:0]    offset_reg, chroma_reg, sat_reg;

    logic                    out_load, head_hold, head_sat, div_last, rem_ge, last_trim;
    logic [CODE_BITS:0]      rem_shift, rem_sub;
    logic [CODE_BITS-1:0]    base_sel, goal_sel;
    logic signed [CODE_BITS:0] diff;
    logic signed [PW-1:0]    prod_c, acc_c;
    logic [CODE_BITS-1:0]    res_c;

    assign head_hold = head.den == '0;
    assign head_sat  = head.num >= head.den;
    assign div_last  = cnt_reg == CNT_BITS'(DW - 1);
    assign last_trim = idx_reg == TRIM_IDX_BITS'(NTRIMS - 1);

    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, job_reg.den};
    assign rem_sub   = rem_shift - {1'b0, job_reg.den};
    assign quo_next  = {quo_reg[DW-2:0], rem_ge};

    assign base_sel = job_reg.base[idx_reg];
    assign goal_sel = job_reg.goal[idx_reg];
    assign diff     = $signed({1'b0, goal_sel}) - $signed({1'b0, base_sel});
    assign prod_c   = PW'(diff) * PW'($signed({1'b0, w_reg}));
    assign acc_c    = $signed({3'b000, base_sel, {WEIGHT_FRAC_BITS{1'b0}}}) + prod_reg + HALF;
    assign res_c    = acc_c[WEIGHT_FRAC_BITS +: CODE_BITS];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (head_hold || head_sat) ? BK_MULT : BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = BK_MULT;
                end
            end
            BK_MULT:
            begin
                state_next = BK_ACCUM;
            end
            BK_ACCUM:
            begin
                state_next = last_trim ? BK_DONE : BK_MULT;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            BK_IDLE:   q_pop = !q_empty;
            BK_DONE:   out_load = !out_valid_reg || !out_stall;
            BK_DIVIDE,
            BK_MULT,
            BK_ACCUM:  q_pop = 1'b0;
            default:   q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head;
            idx_reg <= '0;
            dvd_reg <= DW'({head.num, {WEIGHT_FRAC_BITS{1'b0}}}) + DW'(head.den >> 1);
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            if (head_hold)
            begin
                w_reg <= '0;
            end
            else
            begin
                w_reg <= W_ONE;
            end
        end
        if (state_reg == BK_DIVIDE)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= rem_ge ? rem_sub[CODE_BITS-1:0] : rem_shift[CODE_BITS-1:0];
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (div_last)
            begin
                w_reg <= quo_next[WW-1:0];
            end
        end
        if (state_reg == BK_MULT)
        begin
            prod_reg <= prod_c;
        end
        if (state_reg == BK_ACCUM)
        begin
            res_reg[idx_reg] <= res_c;
            idx_reg <= idx_reg + 1'b1;
        end
        if (out_load)
        begin
            trims_valid_reg <= job_reg.trims_valid;
            case_reg        <= job_reg.kase;
            if (job_reg.trims_valid)
            begin
                slope_reg  <= {1'b0, res_reg[0]} + {1'b0, NEUTRAL};
                offset_reg <= res_reg[1] ^ NEUTRAL;
                power_reg  <= {1'b0, res_reg[2]} + {1'b0, NEUTRAL};
                chroma_reg <= res_reg[3] ^ NEUTRAL;
                sat_reg    <= res_reg[4] ^ NEUTRAL;
            end
            else
            begin
                slope_reg  <= '0;
                offset_reg <= '0;
                power_reg  <= '0;
                chroma_reg <= '0;
                sat_reg    <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign trims_valid     = trims_valid_reg;
    assign case_taken      = case_reg;
    assign slope_coef      = slope_reg;
    assign offset_coef     = $signed(offset_reg);
    assign power_coef      = power_reg;
    assign chroma_coef     = $signed(chroma_reg);
    assign saturation_coef = $signed(sat_reg);

`ifndef SYNTH
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MULT) |-> (w_reg <= W_ONE))
        else $error("blend weight above one");
    a_acc_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ACCUM) |-> !acc_c[PW-1])
        else $error("blend accumulator negative");
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != BK_IDLE))
        else $error("job popped but back end idle");
`endif

endmodule

// ===== dv/display_trim_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module display_trim_interpolator_unit_tb;

    import dti_pkg::*;

    localparam int WF = WEIGHT_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_BEATS = 165;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {
        ROW_ENTRY,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [CODE_BITS-1:0]  target;
        trims_t                trims;
        logic                  last;
    } entry_t;

    typedef struct packed {
        logic                        trims_valid;
        case_t                       kase;
        logic [CODE_BITS:0]          slope;
        logic signed [CODE_BITS-1:0] offset;
        logic [CODE_BITS:0]          power;
        logic signed [CODE_BITS-1:0] chroma;
        logic signed [CODE_BITS-1:0] saturation;
    } coef_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CODE_BITS-1:0]      data;
        entry_t                    e;
        logic                      typed;
        coef_t                     want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CODE_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [LEVEL_BITS-1:0] entry_level;
    logic [CODE_BITS-1:0] target_code;
    logic [CODE_BITS-1:0] slope_trim;
    logic [CODE_BITS-1:0] offset_trim;
    logic [CODE_BITS-1:0] power_trim;
    logic [CODE_BITS-1:0] chroma_trim;
    logic [CODE_BITS-1:0] saturation_trim;
    logic final_entry;
    logic out_valid;
    logic out_stall;
    logic trims_valid;
    logic [1:0] case_taken;
    logic [CODE_BITS:0] slope_coef;
    logic signed [CODE_BITS-1:0] offset_coef;
    logic [CODE_BITS:0] power_coef;
    logic signed [CODE_BITS-1:0] chroma_coef;
    logic signed [CODE_BITS-1:0] saturation_coef;

    display_trim_interpolator_unit i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [CODE_BITS-1:0] disp_peak;
    logic [CODE_BITS-1:0] master_peak;
    logic                 sel_any;
    logic                 below_hit;
    logic [CODE_BITS-1:0] below_gap;
    logic [CODE_BITS-1:0] below_code;
    trims_t               below_set;
    logic                 above_hit;
    logic [CODE_BITS-1:0] above_gap;
    logic [CODE_BITS-1:0] above_code;
    trims_t               above_set;

    coef_t expected_coefs[$];
    row_t  plan[$];
    int    errors = 0;
    int    cycles = 0;
    int    stall_hold = 0;
    bit    quiet_in = 1'b0;
    bit    quiet_out = 1'b0;
    logic [CODE_BITS-1:0] last_target = '0;

    function automatic void clear_selection();
        sel_any = 1'b0;
        below_hit = 1'b0;
        below_gap = CODE_MAX;
        below_code = '0;
        below_set = '0;
        above_hit = 1'b0;
        above_gap = CODE_MAX;
        above_code = '0;
        above_set = '0;
    endfunction

    function automatic longint unsigned trim_weight(int unsigned num, int unsigned den);
        longint unsigned w;
        longint unsigned one;
        one = 64'd1 << WF;
        if (den == 0)
        begin
            return 0;
        end
        w = ((longint'(num) << WF) + den / 2) / den;
        return (w > one) ? one : w;
    endfunction

    function automatic logic [CODE_BITS-1:0] mix_trim(int unsigned a, int unsigned b,
                                                     longint unsigned w);
        longint acc;
        acc = longint'(a) * (64'sd1 <<< WF) + (longint'(b) - longint'(a)) * longint'(w)
            + (64'sd1 <<< (WF - 1));
        if (acc < 0)
        begin
            acc = 0;
        end
        return CODE_BITS'(acc >>> WF);
    endfunction

    // takes one entry in; returns 1 with the frame's coefficients on the last one
    function automatic bit advance_selector(entry_t e, output coef_t r);
        trims_t          t;
        longint unsigned w;
        case_t           k;
        r = '0;
        if (e.level == TRIM_LEVEL)
        begin
            sel_any = 1'b1;
            if (e.target <= disp_peak)
            begin
                if (disp_peak - e.target < below_gap)
                begin
                    below_gap = disp_peak - e.target;
                    below_hit = 1'b1;
                    below_code = e.target;
                    below_set = e.trims;
                end
            end
            else if (e.target - disp_peak < above_gap)
            begin
                above_gap = e.target - disp_peak;
                above_hit = 1'b1;
                above_code = e.target;
                above_set = e.trims;
            end
        end
        if (!e.last)
        begin
            return 1'b0;
        end
        if (sel_any)
        begin
            t = DEFAULT_TRIMS;
            k = CASE_NONE;
            if (below_hit && above_hit)
            begin
                k = CASE_BETWEEN;
                w = trim_weight(disp_peak - below_code, above_code - below_code);
                for (int i = 0; i < NTRIMS; i++)
                begin
                    t[i] = mix_trim(below_set[i], above_set[i], w);
                end
            end
            else if (below_hit)
            begin
                k = CASE_ABOVE_ALL;
                w = 0;
                if (master_peak > below_code)
                begin
                    w = trim_weight(disp_peak - below_code, master_peak - below_code);
                end
                for (int i = 0; i < NTRIMS; i++)
                begin
                    t[i] = mix_trim(below_set[i], NEUTRAL, w);
                end
            end
            else if (above_hit)
            begin
                k = CASE_BELOW_ALL;
                t = above_set;
            end
            r.trims_valid = 1'b1;
            r.kase = k;
            r.slope = (CODE_BITS + 1)'(t[0]) + (CODE_BITS + 1)'(NEUTRAL);
            r.offset = t[1] - NEUTRAL;
            r.power = (CODE_BITS + 1)'(t[2]) + (CODE_BITS + 1)'(NEUTRAL);
            r.chroma = t[3] - NEUTRAL;
            r.saturation = t[4] - NEUTRAL;
        end
        clear_selection();
        return 1'b1;
    endfunction

    function automatic coef_t q12(bit tv, case_t k, int s, int o, int p, int c, int sa);
        coef_t r;
        r.trims_valid = tv;
        r.kase = k;
        r.slope = (CODE_BITS + 1)'(s);
        r.offset = CODE_BITS'(o);
        r.power = (CODE_BITS + 1)'(p);
        r.chroma = CODE_BITS'(c);
        r.saturation = CODE_BITS'(sa);
        return r;
    endfunction

    function automatic void plan_entry(logic [LEVEL_BITS-1:0] level,
                                       logic [CODE_BITS-1:0] target, trims_t trims,
                                       bit last, bit typed = 1'b0, coef_t want = '0);
        row_t r;
        r = '0;
        r.kind = ROW_ENTRY;
        r.e = '{level, target, trims, last};
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic void plan_cfg(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CODE_BITS-1:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        plan.push_back(r);
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return '0;
        end
        if (r < 12)
        begin
            return CODE_MAX;
        end
        return CODE_BITS'($urandom_range(0, 4095));
    endfunction

    function automatic logic [CODE_BITS-1:0] pick_target();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            t = $urandom_range(0, 4095);
        end
        else if (r < 70)
        begin
            t = int'(disp_peak) + int'($urandom_range(0, 80)) - 40;
        end
        else if (r < 78)
        begin
            t = disp_peak;
        end
        else if (r < 88)
        begin
            t = $urandom_range(0, 1) ? 4095 : 0;
        end
        else
        begin
            t = last_target;
        end
        if (t < 0)
        begin
            t = 0;
        end
        if (t > 4095)
        begin
            t = 4095;
        end
        last_target = CODE_BITS'(t);
        return last_target;
    endfunction

    task automatic send_entry(entry_t e, bit typed = 1'b0, coef_t want = '0);
        int    gap;
        coef_t r;
        gap = pick_gap(quiet_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        entry_level <= e.level;
        target_code <= e.target;
        slope_trim <= e.trims[0];
        offset_trim <= e.trims[1];
        power_trim <= e.trims[2];
        chroma_trim <= e.trims[3];
        saturation_trim <= e.trims[4];
        final_entry <= e.last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (advance_selector(e, r))
        begin
            expected_coefs.push_back(typed ? want : r);
        end
    endtask

    task automatic pause_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_coefs.size() != 0);
    endtask

    task automatic wait_drained();
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow beat after beat
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CODE_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_DISPLAY_PEAK: disp_peak = val;
            CFG_MASTER_PEAK:  master_peak = val;
            default:          ;
        endcase
    endtask

    task automatic program_peaks(logic [CODE_BITS-1:0] d, logic [CODE_BITS-1:0] m, int p);
        wait_drained();
        write_reg(CFG_DISPLAY_PEAK, d);
        write_reg(CFG_MASTER_PEAK, m);
        write_reg((p % 2) ? CFG_SPARE_3 : CFG_SPARE_2, CODE_BITS'($urandom_range(0, 4095)));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(output int fed);
        int     n;
        int     kind;
        int     lv;
        entry_t e;
        fed = 0;
        n = $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        for (int j = 0; j < n; j++)
        begin
            lv = TRIM_LEVEL;
            if (kind == 0 || $urandom_range(0, 11) == 0)
            begin
                lv = $urandom_range(0, 255);
            end
            else if (kind == 1)
            begin
                lv = $urandom_range(0, 255);
                if (lv == TRIM_LEVEL)
                begin
                    lv = 8'hFF;
                end
            end
            e.level = LEVEL_BITS'(lv);
            e.target = pick_target();
            for (int i = 0; i < NTRIMS; i++)
            begin
                e.trims[i] = pick_code();
            end
            e.last = (j == n - 1);
            send_entry(e);
            fed++;
        end
    endtask

    always @(posedge clk)
    begin : out_ctl
        int pick;
        if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (quiet_out || pick < 55)
            begin
                out_stall <= 1'b0;
                stall_hold = $urandom_range(0, 7);
            end
            else if (pick < 90)
            begin
                out_stall <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_hold = $urandom_range(9, 39);
            end
        end
    end

    task automatic check_field(string name, logic signed [CODE_BITS+1:0] want,
                               logic signed [CODE_BITS+1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_mon
        coef_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_coefs.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual case %0d",
                         $realtime, case_taken);
                errors++;
            end
            else
            begin
                want = expected_coefs.pop_front();
                check_field("trims_valid", want.trims_valid, trims_valid);
                check_field("case_taken", want.kase, case_taken);
                check_field("slope_coef", want.slope, slope_coef);
                check_field("offset_coef", want.offset, offset_coef);
                check_field("power_coef", want.power, power_coef);
                check_field("chroma_coef", want.chroma, chroma_coef);
                check_field("saturation_coef", want.saturation, saturation_coef);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("display_trim_interpolator_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CODE_BITS-1:0] peaks[8][2];
        int fed;
        int budget;
        int frames;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        entry_level = '0;
        target_code = '0;
        slope_trim = '0;
        offset_trim = '0;
        power_trim = '0;
        chroma_trim = '0;
        saturation_trim = '0;
        final_entry = 1'b0;
        out_stall = 1'b0;
        disp_peak = DISPLAY_PEAK_RST;
        master_peak = MASTER_PEAK_RST;
        clear_selection();

        // reset peaks 2081 / 3079
        plan_entry(8'hFF, CODE_MAX, {NTRIMS{CODE_MAX}}, 1'b0);
        plan_entry(8'd0, '0, '0, 1'b1, 1'b1, q12(0, CASE_NONE, 0, 0, 0, 0, 0));
        plan_entry(TRIM_LEVEL, 12'd2081, '0, 1'b1, 1'b1,
                   q12(1, CASE_ABOVE_ALL, 2048, -2048, 2048, -2048, -2048));
        plan_entry(TRIM_LEVEL, CODE_MAX, {NTRIMS{CODE_MAX}}, 1'b1, 1'b1,
                   q12(1, CASE_BELOW_ALL, 6143, 2047, 6143, 2047, 2047));
        plan_entry(TRIM_LEVEL, 12'd1000, {12'd100, 12'd3500, 12'd7, 12'd2048, 12'd4000}, 1'b0);
        plan_entry(8'd255, 12'd2081, {NTRIMS{12'd1234}}, 1'b0);
        plan_entry(TRIM_LEVEL, 12'd3000, {12'd4095, 12'd0, 12'd2900, 12'd1, 12'd17}, 1'b1);
        // equal distances on one side: first one stays
        plan_entry(TRIM_LEVEL, 12'd2000, {12'd10, 12'd20, 12'd30, 12'd40, 12'd50}, 1'b0);
        plan_entry(TRIM_LEVEL, 12'd2000, {12'd4000, 12'd3000, 12'd2000, 12'd1000, 12'd0}, 1'b0);
        plan_entry(TRIM_LEVEL, 12'd2200, {12'd3333, 12'd111, 12'd2222, 12'd999, 12'd4095}, 1'b1);
        plan_entry(TRIM_LEVEL, 12'd500, {12'd0, 12'd4095, 12'd1000, 12'd3000, 12'd2047}, 1'b1);
        plan_entry(TRIM_LEVEL, 12'd2500, {12'd600, 12'd700, 12'd800, 12'd900, 12'd1000}, 1'b0);
        plan_entry(8'd1, '0, '0, 1'b1);
        plan_entry(TRIM_LEVEL, 12'd3500, {12'd1, 12'd2, 12'd3, 12'd4, 12'd5}, 1'b0);
        plan_entry(TRIM_LEVEL, 12'd2100, {12'd3071, 12'd1025, 12'd4000, 12'd5, 12'd2049}, 1'b1);
        // master below the below target: weight 0
        plan_cfg(CFG_MASTER_PEAK, '0);
        plan_entry(TRIM_LEVEL, 12'd1000, {NTRIMS{CODE_MAX}}, 1'b1, 1'b1,
                   q12(1, CASE_ABOVE_ALL, 6143, 2047, 6143, 2047, 2047));
        // distance 4095 is never taken
        plan_cfg(CFG_DISPLAY_PEAK, CODE_MAX);
        plan_entry(TRIM_LEVEL, '0, {NTRIMS{CODE_MAX}}, 1'b1, 1'b1,
                   q12(1, CASE_NONE, 2049, -2048, 2049, -2048, -2048));
        plan_entry(TRIM_LEVEL, CODE_MAX, '0, 1'b1, 1'b1,
                   q12(1, CASE_ABOVE_ALL, 2048, -2048, 2048, -2048, -2048));
        plan_cfg(CFG_DISPLAY_PEAK, '0);
        plan_entry(TRIM_LEVEL, CODE_MAX, '0, 1'b1, 1'b1,
                   q12(1, CASE_NONE, 2049, -2048, 2049, -2048, -2048));
        plan_cfg(CFG_MASTER_PEAK, CODE_MAX);
        plan_entry(TRIM_LEVEL, '0, {12'd77, 12'd3999, 12'd2048, 12'd5, 12'd4090}, 1'b1);
        plan_entry(TRIM_LEVEL, CODE_MAX, {NTRIMS{12'd3}}, 1'b0);
        plan_entry(TRIM_LEVEL, '0, {12'd4094, 12'd1, 12'd2047, 12'd2049, 12'd0}, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[n].idx, plan[n].data);
                cfg_valid <= 1'b0;
            end
            else
            begin
                send_entry(plan[n].e, plan[n].typed, plan[n].want);
            end
        end

        peaks = '{'{DISPLAY_PEAK_RST, MASTER_PEAK_RST}, '{12'd0, 12'd0},
                  '{CODE_MAX, CODE_MAX}, '{CODE_MAX, 12'd0}, '{12'd0, CODE_MAX},
                  '{12'd0, 12'd0}, '{12'd0, 12'd0}, '{12'd0, 12'd0}};
        for (int p = 5; p < 8; p++)
        begin
            peaks[p][0] = CODE_BITS'($urandom_range(0, 4095));
            peaks[p][1] = CODE_BITS'($urandom_range(0, 4095));
        end

        frames = 0;
        for (int p = 0; p < 8; p++)
        begin
            program_peaks(peaks[p][0], peaks[p][1], p);
            quiet_in = (p == 1) || ($urandom_range(0, 3) == 0);
            quiet_out = (p == 1) || ($urandom_range(0, 3) == 0);
            budget = 0;
            while (budget < PHASE_BEATS)
            begin
                run_frame(fed);
                budget += fed;
                frames++;
                if (frames % 29 == 7)
                begin
                    pause_for_results();
                end
            end
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("display_trim_interpolator_unit_tb: done, clean");
        end
        else
        begin
            $display("display_trim_interpolator_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
